[rtl/core/ismt_pkg.sv]
// Shared types and constants for the integer set membership table.
package ismt_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int TOTAL_W  = 7;
	localparam int OUT_W    = 16;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_ERASE = 2'd1,
		OP_TEST  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_COMMIT = 1'b1
	} state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic    lookup;
		logic    commit;
		opcode_t op;
	} cell_ctl_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

endpackage

[rtl/core/ismt_cell.sv]
// One storage cell: holds an entry and its valid bit, compares against the request.
module ismt_cell
	import ismt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [VAL_W-1:0] cmp_value,
	input  logic [VAL_W-1:0] wr_value,
	input  logic             grant,
	output logic             valid,
	output logic             match
);

	logic             valid_q;
	logic [VAL_W-1:0] value_q;
	logic             match_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (ctl.lookup) begin
				match_s1 <= valid_q && (value_q == cmp_value);
			end
			if (ctl.commit) begin
				case (ctl.op)
					OP_CLEAR: valid_q <= 1'b0;
					OP_ERASE: if (match_s1) valid_q <= 1'b0;
					OP_ADD:   if (grant) valid_q <= 1'b1;
					default:  valid_q <= valid_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && ctl.op == OP_ADD && grant) begin
			value_q <= wr_value;
		end
	end

	assign valid = valid_q;
	assign match = match_s1;

endmodule

[rtl/core/ismt_pick.sv]
// Reduces the cell row: any hit, full flag and one-hot grant of the lowest free cell.
module ismt_pick
	import ismt_pkg::*;
(
	input  logic [CAPACITY-1:0] valid,
	input  logic [CAPACITY-1:0] match,
	output logic                hit,
	output logic                full,
	output logic [CAPACITY-1:0] lowest_free
);

	logic [CAPACITY-1:0] free;

	assign free        = ~valid;
	// isolate lowest set bit: x & -x
	assign lowest_free = free & (~free + CAPACITY'(1));
	assign full        = ~|free;
	assign hit         = |match;

endmodule

[rtl/core/integer_set_membership_table.sv]
// Integer set membership table: a row of compare cells holding a set of distinct values.
//
// Input channel s_axis: s_axis_tuser carries the request kind (0 add, 1 erase,
// 2 test, 3 clear), s_axis_tdata the signed 32-bit value (ignored for clear).
// Output channel m_axis: one word per request with was_present, the member
// count after the request and a status bit (1: add dropped, table full).
// A word is accepted when tvalid and tready are both high.
// Every cell compares the incoming value in the accept cycle; the commit state
// then reduces the hit flags, picks the lowest free cell and commits the update.
// A new request is not taken until the previous one has been committed, since
// the compare and commit steps over the cell row alternate.
// The result sits in an output register, so the next request is accepted
// while the previous result still waits. If the receiver stalls with a result
// pending, the commit step holds and no further request is accepted.
// Reset empties the set (all valid bits and the count to zero); no clearing
// pass is needed and the block is ready as soon as reset is released.
module integer_set_membership_table
	import ismt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [31:0]      s_axis_tdata,   // [31:0] value
	input  logic [1:0]       s_axis_tuser,   // [1:0] opcode
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // [0] was_present, [7:1] member_total, [8] status
);

	state_t state_q, state_d;

	opcode_t                op_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic [CNT_W-1:0]       count_q, count_d;

	logic                   out_valid_q;
	logic                   out_present_q;
	logic [TOTAL_W-1:0]     out_total_q;
	logic                   out_status_q;

	logic                   accept;
	logic                   commit;
	cell_ctl_t              ctl;
	logic [CAPACITY-1:0]    valid_vec;
	logic [CAPACITY-1:0]    match_vec;
	logic [CAPACITY-1:0]    lowest_free;
	logic [CAPACITY-1:0]    grant_vec;
	logic                   hit;
	logic                   full;
	logic                   add_ok;
	logic                   status_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_COMMIT;
			ST_COMMIT: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		commit        = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_COMMIT: commit = !out_valid_q || m_axis_tready;
			default:   s_axis_tready = 1'b0;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode_t'(s_axis_tuser);
			value_s1 <= s_axis_tdata;
		end
	end

	assign ctl.lookup = accept;
	assign ctl.commit = commit;
	assign ctl.op     = op_s1;

	assign add_ok    = (op_s1 == OP_ADD) && !hit && !full;
	assign grant_vec = add_ok ? lowest_free : '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ismt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cmp_value (s_axis_tdata),
			.wr_value  (value_s1),
			.grant     (grant_vec[i]),
			.valid     (valid_vec[i]),
			.match     (match_vec[i])
		);
	end

	ismt_pick u_pick (
		.valid       (valid_vec),
		.match       (match_vec),
		.hit         (hit),
		.full        (full),
		.lowest_free (lowest_free)
	);

	always_comb begin
		count_d  = count_q;
		status_d = STATUS_OK;
		case (op_s1)
			OP_CLEAR: count_d = '0;
			OP_ADD: begin
				if (add_ok) begin
					count_d = count_q + CNT_W'(1);
				end else if (!hit) begin
					status_d = STATUS_FULL;
				end
			end
			OP_ERASE: if (hit) count_d = count_q - CNT_W'(1);
			default:  count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_present_q <= (op_s1 != OP_CLEAR) && hit;
			out_total_q   <= TOTAL_W'(count_d);
			out_status_q  <= status_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W - TOTAL_W - 2)'(0), out_status_q, out_total_q, out_present_q};

endmodule

[dv/set_membership_checker.sv]
// Checker for the integer set membership table: predicts each reply and compares it.
`timescale 1ns / 1ps

module set_membership_checker
	import ismt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [31:0]      s_axis_tdata,   // [31:0] value
	input  logic [1:0]       s_axis_tuser,   // [1:0] opcode
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,   // [0] was_present, [7:1] member_total, [8] status
	output int               mismatch_count,
	output int               replies_due
);

	typedef struct packed {
		logic               was_present;
		logic [TOTAL_W-1:0] member_total;
		logic               status;
	} reply_t;

	logic [VAL_W-1:0] slot_value [CAPACITY];
	logic             slot_used  [CAPACITY];
	int unsigned      members;
	reply_t           expected_replies [$];

	// Applies one request to the shadow set and returns the reply it should give.
	function automatic reply_t apply_request(opcode_t op, logic [VAL_W-1:0] v);
		reply_t r;
		int     hit;
		int     free_slot;
		hit       = -1;
		free_slot = -1;
		r         = '0;
		if (op == OP_CLEAR) begin
			for (int i = 0; i < CAPACITY; i++)
				slot_used[i] = 1'b0;
			members = 0;
		end else begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (slot_used[i] && slot_value[i] == v && hit < 0)
					hit = i;
				if (!slot_used[i] && free_slot < 0)
					free_slot = i;
			end
			r.was_present = (hit >= 0);
			if (op == OP_ADD && hit < 0) begin
				if (free_slot >= 0) begin
					slot_value[free_slot] = v;
					slot_used[free_slot]  = 1'b1;
					members++;
				end else begin
					r.status = STATUS_FULL;
				end
			end else if (op == OP_ERASE && hit >= 0) begin
				slot_used[hit] = 1'b0;
				members--;
			end
		end
		r.member_total = members[TOTAL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_used[i]  = 1'b0;
				slot_value[i] = '0;
			end
			members = 0;
			expected_replies.delete();
			mismatch_count <= 0;
			replies_due    <= 0;
		end else begin
			// check the outgoing word before queuing the new request
			if (m_axis_tvalid && m_axis_tready) begin
				got.was_present  = m_axis_tdata[0];
				got.member_total = m_axis_tdata[7:1];
				got.status       = m_axis_tdata[8];
				if (expected_replies.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: reply word with nothing pending: present=%0d total=%0d status=%0d",
							$time, got.was_present, got.member_total, got.status);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_replies.pop_front();
					if (got.was_present !== want.was_present || got.member_total !== want.member_total
							|| got.status !== want.status) begin
						if (mismatch_count < 10)
							$display("%0t: reply mismatch: expected present=%0d total=%0d status=%0d, got present=%0d total=%0d status=%0d",
								$time, want.was_present, want.member_total, want.status,
								got.was_present, got.member_total, got.status);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_replies.push_back(apply_request(opcode_t'(s_axis_tuser), s_axis_tdata));
			replies_due <= expected_replies.size();
		end
	end

endmodule

[dv/integer_set_membership_table_tb.sv]
// Testbench top for the integer set membership table: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module integer_set_membership_table_tb;
	import ismt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_SIZE   = 80;
	localparam int RANDOM_REQS = 610;
	localparam int FILL_REQS   = 70;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata;   // [31:0] value
	logic [1:0]       s_axis_tuser;   // [1:0] opcode
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // [0] was_present, [7:1] member_total, [8] status

	int          mismatch_count;
	int          replies_due;
	int          cycle_count;
	int          sent_count;
	int          taken_count;
	logic [31:0] value_pool [POOL_SIZE];

	integer_set_membership_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	set_membership_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.replies_due    (replies_due)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Returns after the word is taken; valid stays up so a back-to-back word follows cleanly.
	task automatic send_request(opcode_t op, logic [31:0] v);
		int gap;
		gap = (((sent_count / 50) % 4) == 3) ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sent_count++;
	endtask

	// Holds off the sender until every reply in flight has come back.
	task automatic wait_for_replies();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (replies_due != 0) @(negedge clk);
	endtask

	// receiver side: random stalls per word, with stretches of none
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = (((taken_count / 40) % 4) == 2) ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken_count++;
		end
	end

	initial begin
		int      roll;
		opcode_t op;
		logic [31:0] v;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_ADD;
		m_axis_tready = 1'b0;
		cycle_count   = 0;
		sent_count    = 0;
		taken_count   = 0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty-set lookups, extremes, duplicates, reuse of a freed slot, clear
		send_request(OP_TEST,  32'h0000_0000);
		send_request(OP_ERASE, 32'h0000_0005);
		send_request(OP_ADD,   32'h8000_0000);
		send_request(OP_ADD,   32'h7fff_ffff);
		send_request(OP_ADD,   32'h0000_0000);
		send_request(OP_ADD,   32'hffff_ffff);
		send_request(OP_ADD,   32'h8000_0000);
		send_request(OP_TEST,  32'h7fff_ffff);
		send_request(OP_TEST,  32'h0000_0001);
		send_request(OP_ERASE, 32'h0000_0000);
		send_request(OP_ERASE, 32'h0000_0000);
		send_request(OP_TEST,  32'h0000_0000);
		send_request(OP_ADD,   32'h0000_0000);
		send_request(OP_CLEAR, 32'hdead_beef);
		send_request(OP_TEST,  32'hffff_ffff);
		send_request(OP_CLEAR, 32'hffff_ffff);
		send_request(OP_ADD,   32'h5555_aaaa);
		send_request(OP_ADD,   32'haaaa_5555);
		send_request(OP_TEST,  32'haaaa_5555);
		wait_for_replies();

		// fill past capacity so adds get dropped, then probe the full store
		for (int i = 0; i < FILL_REQS; i++)
			send_request(OP_ADD, $urandom);
		send_request(OP_ADD,  32'h5555_aaaa);
		send_request(OP_TEST, 32'h5555_aaaa);
		send_request(OP_ERASE, 32'h5555_aaaa);
		send_request(OP_ADD,  32'h0123_4567);
		send_request(OP_ADD,  32'h7654_3210);

		// random mix drawn mostly from a small pool so the set runs near full
		for (int i = 0; i < RANDOM_REQS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 1)
				op = OP_CLEAR;
			else if (roll < 46)
				op = OP_ADD;
			else if (roll < 66)
				op = OP_ERASE;
			else
				op = OP_TEST;
			if ($urandom_range(0, 99) < 15)
				v = $urandom;
			else
				v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_request(op, v);
			if (i % 150 == 149)
				wait_for_replies();
		end

		wait_for_replies();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/core/ismt_pkg.sv
rtl/core/ismt_cell.sv
rtl/core/ismt_pick.sv
rtl/core/integer_set_membership_table.sv
dv/set_membership_checker.sv
dv/integer_set_membership_table_tb.sv
